>>> design/scl_pkg.sv
// Package for the serial command line recognizer: types, constants, keyword tables.
`timescale 1ns / 1ps
package scl_pkg;

  localparam int LineDepth = 128;
  localparam int AddrW = $clog2(LineDepth);
  localparam int LenW = $clog2(LineDepth + 1);

  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  localparam logic [3:0] CmdUnknown = 4'd0;
  localparam logic [3:0] CmdAck = 4'd1;
  localparam logic [3:0] CmdNak = 4'd2;
  localparam logic [3:0] CmdCan = 4'd3;
  localparam logic [3:0] CmdVer = 4'd4;
  localparam logic [3:0] CmdSntp = 4'd5;
  localparam logic [3:0] CmdBme = 4'd6;
  localparam logic [3:0] CmdFtpList = 4'd7;
  localparam logic [3:0] CmdList = 4'd8;
  localparam logic [3:0] CmdFtpGet = 4'd9;
  localparam logic [3:0] CmdTelnet = 4'd10;
  localparam logic [3:0] CmdSpiffsList = 4'd11;
  localparam logic [3:0] CmdSpiffsGet = 4'd12;

  localparam int NumKw = 9;
  localparam int KwMax = 10;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       transfer_active;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  command_code;
    logic [11:0] file_number;
    logic [6:0]  term_width;
    logic [7:0]  term_height;
  } out_item_t;

  // Keyword character at a position; order VER SNTP BME FTPLIST LIST: FTPGET:
  // TELNET: SPIFFSLIST SPIFFSGET:.
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
    logic [8*KwMax-1:0] s;
    s = '0;
    unique case (k)
      4'd0: s[8*KwMax-1 -: 24] = "VER";
      4'd1: s[8*KwMax-1 -: 32] = "SNTP";
      4'd2: s[8*KwMax-1 -: 24] = "BME";
      4'd3: s[8*KwMax-1 -: 56] = "FTPLIST";
      4'd4: s[8*KwMax-1 -: 40] = "LIST:";
      4'd5: s[8*KwMax-1 -: 56] = "FTPGET:";
      4'd6: s[8*KwMax-1 -: 56] = "TELNET:";
      4'd7: s[8*KwMax-1 -: 80] = "SPIFFSLIST";
      4'd8: s[8*KwMax-1 -: 80] = "SPIFFSGET:";
      default: s = '0;
    endcase
    return s[8*KwMax-1 - 8*p -: 8];
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    unique case (k)
      4'd0, 4'd2: return 4'd3;
      4'd1: return 4'd4;
      4'd4: return 4'd5;
      4'd3, 4'd5, 4'd6: return 4'd7;
      4'd7, 4'd8: return 4'd10;
      default: return 4'd0;
    endcase
  endfunction

  // Keyword that must match the whole text, versus a prefix.
  function automatic logic kw_exact(input logic [3:0] k);
    return (k == 4'd0) || (k == 4'd1) || (k == 4'd2) || (k == 4'd3) || (k == 4'd7);
  endfunction

  function automatic logic [3:0] kw_code(input logic [3:0] k);
    unique case (k)
      4'd0: return CmdVer;
      4'd1: return CmdSntp;
      4'd2: return CmdBme;
      4'd3: return CmdFtpList;
      4'd4: return CmdList;
      4'd5: return CmdFtpGet;
      4'd6: return CmdTelnet;
      4'd7: return CmdSpiffsList;
      4'd8: return CmdSpiffsGet;
      default: return CmdUnknown;
    endcase
  endfunction

  // Commands and status between the controller and the datapath.
  typedef enum logic [3:0] {
    OP_NONE, OP_STORE, OP_CLEAR, OP_SKIP, OP_END, OP_KW, OP_NUM, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] kw;
    logic [1:0] num_sel;   // 0 file, 1 width, 2 height
    logic       first;     // start of a scan phase
  } dp_cmd_t;

  typedef struct packed {
    logic       phase_done;
    logic       kw_hit;
    logic       early_code;
    logic       line_end;
    logic       simple_end;
  } dp_stat_t;

endpackage

>>> design/scl_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module scl_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // A read during a write returns the old contents; read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/scl_datapath.sv
// Datapath: line buffer, scan pointers, keyword compare and number decode.
`timescale 1ns / 1ps
module scl_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  scl_pkg::in_item_t    in_item,
  input  scl_pkg::dp_cmd_t     cmd,
  output scl_pkg::dp_stat_t    stat,
  output scl_pkg::out_item_t   result
);
  import scl_pkg::*;

  logic [LenW-1:0]  line_length;
  logic             line_overflow;
  logic [15:0]      last_two_bytes;
  logic [LenW-1:0]  ptr;        // address issued this cycle
  logic [LenW-1:0]  rptr;       // address of rdata
  logic             rvalid;
  logic [7:0]       prev;
  logic [LenW-1:0]  start_pos;
  logic [LenW-1:0]  end_pos;
  logic [LenW-1:0]  num_end;
  logic             hit;
  logic [11:0]      acc;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]       rdata;
  logic [LenW-1:0]  cend;
  logic [LenW-1:0]  txt_len;
  logic [LenW-1:0]  rel;
  logic [LenW-1:0]  ptr_next;
  logic             is_digit;
  logic [15:0]      acc_x10;
  logic [11:0]      lim;
  logic [LenW-1:0]  num_start;
  logic             phase_done;
  logic             char_ok;

  assign cend    = line_length - LenW'(2);
  assign txt_len = end_pos - start_pos;
  assign rel     = rptr - start_pos;
  assign is_digit = (rdata >= "0") && (rdata <= "9");
  assign ram_we   = (cmd.op == OP_STORE) && (line_length < LenW'(LineDepth));
  assign ram_addr = ram_we ? line_length[AddrW-1:0] : ptr[AddrW-1:0];

  scl_ram #(.Width(8), .Depth(LineDepth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_item.rx_byte), .rdata(rdata)
  );

  // Number phase start and limit.
  always_comb begin
    unique case (cmd.num_sel)
      2'd1: begin num_start = start_pos + LenW'(7); lim = 12'd99; end
      2'd2: begin num_start = start_pos + LenW'(10); lim = 12'd255; end
      default: begin
        num_start = start_pos + LenW'(kw_len(cmd.kw)); lim = 12'd4095;
      end
    endcase
    acc_x10 = {4'd0, acc} * 16'd10 + {8'd0, rdata - 8'h30};
  end

  // Scan phases finish when the read pointer runs off the range, or on a mismatch, NUL or non-digit.
  always_comb begin
    phase_done = 1'b0;
    unique case (cmd.op)
      OP_SKIP: phase_done = !cmd.first && rvalid && (rptr + LenW'(1) >= cend);
      OP_END:  phase_done = !cmd.first && rvalid && (rptr >= cend || rdata == 8'd0);
      OP_KW:   phase_done = !cmd.first && rvalid &&
                 (!hit || rel >= {{(LenW-4){1'b0}}, kw_len(cmd.kw)} - LenW'(1) ||
                  rel >= txt_len);
      OP_NUM:  phase_done = !cmd.first && rvalid &&
                 (rptr >= num_end || !is_digit);
      default: phase_done = 1'b0;
    endcase
    ptr_next = cmd.first ? ((cmd.op == OP_NUM) ? num_start : start_pos) : ptr + LenW'(1);
    if (cmd.first && cmd.op == OP_SKIP) ptr_next = '0;
  end

  assign stat.phase_done = phase_done;

  // The character read in the finishing cycle counts toward the keyword hit.
  assign char_ok = (rel >= txt_len) || (rdata == kw_char(cmd.kw, rel[3:0]));
  assign stat.kw_hit = hit && char_ok && (kw_exact(cmd.kw) ?
      (txt_len == LenW'(kw_len(cmd.kw))) : (txt_len >= LenW'(kw_len(cmd.kw))));
  assign stat.early_code = !line_overflow && line_length == LenW'(1) &&
      (last_two_bytes[7:0] == ChAck || last_two_bytes[7:0] == ChNak ||
       last_two_bytes[7:0] == ChCan);
  assign stat.line_end = last_two_bytes == {ChCr, ChLf};
  assign stat.simple_end = line_overflow || line_length < LenW'(2);

  // Line state, scan pointers and result assembly.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      line_overflow <= 1'b0;
      last_two_bytes <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= 1'b0;
      unique case (cmd.op)
        OP_STORE: begin
          if (line_length < LenW'(LineDepth)) line_length <= line_length + LenW'(1);
          else line_overflow <= 1'b1;
          last_two_bytes <= {last_two_bytes[7:0], in_item.rx_byte};
          result <= '0;
          unique case (in_item.rx_byte)
            ChAck: result.command_code <= CmdAck;
            ChNak: result.command_code <= CmdNak;
            ChCan: result.command_code <= CmdCan;
            default: result.command_code <= CmdUnknown;
          endcase
        end
        OP_CLEAR: begin
          line_length <= '0;
          line_overflow <= 1'b0;
          last_two_bytes <= '0;
        end
        OP_SKIP, OP_END, OP_KW, OP_NUM: begin
          ptr <= ptr_next;
          rptr <= ptr;
          rvalid <= !cmd.first;
          if (cmd.first) begin
            prev <= 8'd0;
            hit <= 1'b1;
            acc <= '0;
            if (cmd.op == OP_SKIP) start_pos <= '0;
            if (cmd.op == OP_END) end_pos <= start_pos;
            if (cmd.op == OP_NUM) begin
              num_end <= (cmd.num_sel == 2'd1 && start_pos + LenW'(9) < end_pos) ?
                         start_pos + LenW'(9) : end_pos;
            end
          end else if (rvalid) begin
            unique case (cmd.op)
              OP_SKIP: begin
                prev <= rdata;
                if (prev == ChCr && rdata == ChLf && start_pos == '0 && rptr < cend)
                  start_pos <= rptr + LenW'(1);
              end
              OP_END: if (!(rptr >= cend || rdata == 8'd0)) end_pos <= rptr + LenW'(1);
              OP_KW: if (rel < txt_len && rdata != kw_char(cmd.kw, rel[3:0])) hit <= 1'b0;
              OP_NUM: if (rptr < num_end && is_digit)
                acc <= (acc_x10 > {4'd0, lim}) ? lim : acc_x10[11:0];
              default: ;
            endcase
          end
        end
        OP_OUT: begin
          result <= '0;
        end
        default: ;
      endcase
      // Latch pieces of the result as phases finish.
      if (cmd.op == OP_KW && phase_done && stat.kw_hit)
        result.command_code <= kw_code(cmd.kw);
      if (cmd.op == OP_NUM && phase_done) begin
        unique case (cmd.num_sel)
          2'd1: result.term_width <= acc[6:0];
          2'd2: result.term_height <= acc[7:0];
          default: result.file_number <= acc;
        endcase
      end
    end
  end
endmodule

>>> design/scl_ctrl.sv
// Controller: sequences storing, line-end scans and result handoff.
`timescale 1ns / 1ps
module scl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                xfer,
  output logic                out_valid,
  input  logic                out_ready,
  input  scl_pkg::dp_stat_t   stat,
  output scl_pkg::dp_cmd_t    cmd
);
  import scl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SKIP, S_END, S_KW, S_NUM1, S_NUM2, S_CLEAR, S_SEND
  } state_t;

  state_t     state;
  logic       first;
  logic [3:0] kw;
  logic       active;
  logic       is_telnet;

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Commands for the datapath follow the state.
  always_comb begin
    cmd = '{op: OP_NONE, kw: kw, num_sel: 2'd0, first: first};
    unique case (state)
      S_IDLE:  if (in_valid && in_ready) cmd.op = OP_STORE;
      S_SKIP:  cmd.op = OP_SKIP;
      S_END:   cmd.op = OP_END;
      S_KW:    cmd.op = OP_KW;
      S_NUM1:  begin cmd.op = OP_NUM; cmd.num_sel = is_telnet ? 2'd1 : 2'd0; end
      S_NUM2:  begin cmd.op = OP_NUM; cmd.num_sel = 2'd2; end
      S_CLEAR: cmd.op = OP_CLEAR;
      default: cmd.op = OP_NONE;
    endcase
  end

  // State register and handshake flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b1;
      kw <= '0;
      active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          active <= xfer;
          state <= S_CHECK;
        end
        S_CHECK: begin
          first <= 1'b1;
          if (stat.early_code) begin
            out_valid <= 1'b1;
            state <= S_CLEAR;
          end else if (!active && stat.line_end) begin
            state <= stat.simple_end ? S_SEND : S_SKIP;
          end else state <= S_IDLE;
        end
        S_SKIP: begin
          first <= 1'b0;
          if (stat.phase_done) begin first <= 1'b1; state <= S_END; end
        end
        S_END: begin
          first <= 1'b0;
          if (stat.phase_done) begin first <= 1'b1; kw <= '0; state <= S_KW; end
        end
        S_KW: begin
          first <= 1'b0;
          if (stat.phase_done) begin
            first <= 1'b1;
            if (stat.kw_hit) begin
              is_telnet <= (kw == 4'd6);
              state <= kw_exact(kw) ? S_SEND : S_NUM1;
            end else if (kw == 4'(NumKw - 1)) begin
              state <= S_SEND;
            end else kw <= kw + 4'd1;
          end
        end
        S_NUM1: begin
          first <= 1'b0;
          if (stat.phase_done) begin
            first <= 1'b1;
            state <= is_telnet ? S_NUM2 : S_SEND;
          end
        end
        S_NUM2: begin
          first <= 1'b0;
          if (stat.phase_done) begin first <= 1'b1; state <= S_SEND; end
        end
        S_SEND: begin
          out_valid <= 1'b1;
          state <= S_CLEAR;
        end
        S_CLEAR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/serial_command_line_recognizer.sv
// Top level of the serial command line recognizer.
`timescale 1ns / 1ps
//  channel  signals                  direction  carries
//  in       in_valid/in_ready/in     sink       received byte and transfer flag
//  out      out_valid/out_ready/out  source     command code and decoded numbers
// A byte without line end is stored and then checked. A CR LF line is scanned in the
// controller's sequence: garbage skip, text end, up to nine keyword compares and
// up to two number reads, each one RAM read per cycle. Reset clears the line
// state; no clearing pass. A stalled result holds the block idle until taken.
module serial_command_line_recognizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  scl_pkg::in_item_t   in,
  output logic                out_valid,
  input  logic                out_ready,
  output scl_pkg::out_item_t  out
);
  import scl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  scl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .xfer(in.transfer_active), .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  scl_datapath u_dp (
    .clk(clk), .rst(rst), .in_item(in), .cmd(cmd), .stat(stat), .result(out)
  );

  // No new byte is taken while a result waits.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input accepted while result pending");
  // Result codes stay in range.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> out.command_code <= CmdSpiffsGet)
    else $error("command code out of range");
  // Non-telnet results carry no terminal size.
  assert property (@(posedge clk) disable iff (rst)
      out_valid && out.command_code != CmdTelnet |-> out.term_width == '0 && out.term_height == '0)
    else $error("terminal size on wrong code");
endmodule

>>> sim/scl_checker.sv
// Checker for the serial command line recognizer: predicts results and compares them.
`timescale 1ns / 1ps
module scl_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  scl_pkg::in_item_t  in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  scl_pkg::out_item_t out,
  output int                 errors,
  output int                 pending
);
  import scl_pkg::*;

  // Mirror of the line state.
  logic [7:0]  line_mem [LineDepth];
  int          line_len;
  logic        line_ovf;
  logic [15:0] tail_pair;

  // Commands predicted but not yet seen at the output.
  out_item_t   cmd_queue [$];

  // Decimal digits from p up to e, saturating at lim.
  function automatic int scan_decimal(input int p, input int e, input int lim);
    int v;
    v = 0;
    while (p < e && p < LineDepth && line_mem[p] >= "0" && line_mem[p] <= "9") begin
      v = v * 10 + (line_mem[p] - "0");
      if (v > lim) v = lim;
      p++;
    end
    return v;
  endfunction

  // Compare text at s of length n with a keyword, whole word or prefix.
  function automatic bit keyword_at(input int s, input int n, input string kw,
                                    input bit whole);
    if (whole ? (n != kw.len()) : (n < kw.len())) return 0;
    for (int i = 0; i < kw.len(); i++) begin
      if (line_mem[s + i] != kw[i]) return 0;
    end
    return 1;
  endfunction

  // Decode a complete CR LF line.
  function automatic out_item_t decode_line();
    out_item_t r;
    int cend, s, e, n, we;
    r = '0;
    cend = line_len - 2;
    s = 0;
    for (int i = 0; i + 1 < cend; i++) begin
      if (line_mem[i] == ChCr && line_mem[i + 1] == ChLf) begin
        s = i + 2;
        break;
      end
    end
    e = s;
    while (e < cend && line_mem[e] != 8'd0) e++;
    n = e - s;
    if (keyword_at(s, n, "VER", 1)) r.command_code = CmdVer;
    else if (keyword_at(s, n, "SNTP", 1)) r.command_code = CmdSntp;
    else if (keyword_at(s, n, "BME", 1)) r.command_code = CmdBme;
    else if (keyword_at(s, n, "FTPLIST", 1)) r.command_code = CmdFtpList;
    else if (keyword_at(s, n, "LIST:", 0)) begin
      r.command_code = CmdList;
      r.file_number = 12'(scan_decimal(s + 5, e, 4095));
    end else if (keyword_at(s, n, "FTPGET:", 0)) begin
      r.command_code = CmdFtpGet;
      r.file_number = 12'(scan_decimal(s + 7, e, 4095));
    end else if (keyword_at(s, n, "TELNET:", 0)) begin
      we = (s + 9 < e) ? s + 9 : e;
      r.command_code = CmdTelnet;
      r.term_width = 7'(scan_decimal(s + 7, we, 99));
      r.term_height = 8'(scan_decimal(s + 10, e, 255));
    end else if (keyword_at(s, n, "SPIFFSLIST", 1)) r.command_code = CmdSpiffsList;
    else if (keyword_at(s, n, "SPIFFSGET:", 0)) begin
      r.command_code = CmdSpiffsGet;
      r.file_number = 12'(scan_decimal(s + 10, e, 4095));
    end
    return r;
  endfunction

  // Advance the line state by one received byte.
  task automatic take_byte(input in_item_t it);
    out_item_t r;
    logic [7:0] b;
    b = it.rx_byte;
    r = '0;
    if (line_len < LineDepth) begin
      line_mem[line_len] = b;
      line_len++;
    end else begin
      line_ovf = 1;
    end
    tail_pair = {tail_pair[7:0], b};
    if (!line_ovf && line_len == 1 && (b == ChAck || b == ChNak || b == ChCan)) begin
      r.command_code = (b == ChAck) ? CmdAck : (b == ChNak) ? CmdNak : CmdCan;
      cmd_queue.push_back(r);
      line_len = 0; line_ovf = 0; tail_pair = '0;
    end else if (!it.transfer_active && tail_pair == {ChCr, ChLf}) begin
      if (!line_ovf && line_len >= 2) r = decode_line();
      cmd_queue.push_back(r);
      line_len = 0; line_ovf = 0; tail_pair = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Watch both channels at the rising edge.
  initial errors = 0;
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      line_len = 0; line_ovf = 0; tail_pair = '0;
      cmd_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (cmd_queue.size() == 0) begin
          report_mismatch("unexpected item, code", out.command_code, -1);
        end else begin
          want = cmd_queue.pop_front();
          if (out.command_code != want.command_code)
            report_mismatch("command_code", out.command_code, want.command_code);
          if (out.file_number != want.file_number)
            report_mismatch("file_number", out.file_number, want.file_number);
          if (out.term_width != want.term_width)
            report_mismatch("term_width", out.term_width, want.term_width);
          if (out.term_height != want.term_height)
            report_mismatch("term_height", out.term_height, want.term_height);
        end
      end
      if (in_valid && in_ready) take_byte(in);
    end
    pending <= cmd_queue.size();
  end
endmodule

>>> sim/tb_top.sv
// Testbench top for the serial command line recognizer: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
  import scl_pkg::*;

  localparam int StallLimit = 6000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_item;
  int errors, pending;

  int bytes_sent = 0;
  bit hold_request = 0;
  int hold_count = 0;
  int quiet_cycles = 0;
  logic [7:0] line_bytes [$];

  always #5 clk = ~clk;

  serial_command_line_recognizer uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out(out_item)
  );

  scl_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out(out_item),
    .errors(errors), .pending(pending)
  );

  // Idle rates change with progress: receiver idle first, sender idle second.
  function automatic int idle_pct(input bit sender);
    if (bytes_sent < 400) return sender ? 14 : 77;
    if (bytes_sent < 800) return sender ? 77 : 14;
    return 0;
  endfunction

  // Receiver readiness, with a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_request && hold_count < 400) begin
      hold_count <= hold_count + 1;
      out_ready <= 0;
    end else begin
      if (hold_count >= 400) begin
        hold_request <= 0;
        hold_count <= 0;
      end
      out_ready <= ($urandom_range(99) >= idle_pct(0));
    end
  end

  // Stall watchdog: counts cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles first.
  task automatic send_byte(input logic [7:0] b, input logic ta);
    while ($urandom_range(99) < idle_pct(1)) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_item <= '{rx_byte: b, transfer_active: ta};
    do @(posedge clk); while (!(in_valid && in_ready));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(input logic ta);
    foreach (line_bytes[i]) send_byte(line_bytes[i], ta);
    line_bytes.delete();
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic put_digits(input int n);
    repeat (n) line_bytes.push_back(8'("0") + 8'($urandom_range(9)));
  endtask

  task automatic put_noise(input int n);
    repeat (n) line_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_crlf();
    line_bytes.push_back(ChCr);
    line_bytes.push_back(ChLf);
  endtask

  // One well-formed command with random numbers, or noise.
  task automatic random_line();
    int kind;
    kind = $urandom_range(15);
    if ($urandom_range(7) == 0) begin
      put_noise($urandom_range(6));
      put_crlf();
    end
    case (kind)
      0: line_bytes.push_back($urandom_range(2) == 0 ? ChAck :
                              ($urandom_range(1) ? ChNak : ChCan));
      1: put_text("VER");
      2: put_text("SNTP");
      3: put_text("BME");
      4: put_text("FTPLIST");
      5: begin put_text("LIST:"); put_digits($urandom_range(6)); end
      6: begin put_text("FTPGET:"); put_digits($urandom_range(6)); end
      7, 8: begin
        put_text("TELNET:");
        put_digits($urandom_range(3));
        put_noise($urandom_range(1));
        put_digits($urandom_range(4));
      end
      9: put_text("SPIFFSLIST");
      10: begin put_text("SPIFFSGET:"); put_digits($urandom_range(6)); end
      11: begin put_text("LIST:"); put_noise($urandom_range(3)); end
      default: put_noise($urandom_range(12));
    endcase
    if (kind != 0) begin
      if ($urandom_range(9) == 0) put_noise(1);
      put_crlf();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed part: early codes, every keyword, saturation, garbage, NUL, short forms.
    line_bytes.push_back(ChAck); line_bytes.push_back(ChNak);
    line_bytes.push_back(ChCan); send_line(0);
    put_text("VER"); put_crlf(); put_text("SNTP"); put_crlf(); send_line(0);
    put_text("BME"); put_crlf(); put_text("FTPLIST"); put_crlf(); send_line(0);
    put_text("LIST:4095"); put_crlf(); put_text("FTPGET:99999"); put_crlf(); send_line(0);
    put_text("TELNET:80,24"); put_crlf(); put_text("TELNET:8"); put_crlf(); send_line(0);
    put_text("TELNET:99x999"); put_crlf(); send_line(0);
    put_text("SPIFFSLIST"); put_crlf(); put_text("SPIFFSGET:7"); put_crlf(); send_line(0);
    line_bytes.push_back(8'hFF); put_crlf(); put_text("VER"); put_crlf(); send_line(0);
    put_text("BME"); line_bytes.push_back(8'h00); put_text("Q"); put_crlf(); send_line(0);
    put_crlf(); put_text("VERX"); put_crlf(); send_line(0);
    put_text("LIST:"); put_crlf(); send_line(1);
    put_text("VER"); put_crlf(); send_line(0);
    put_noise(130); put_crlf(); send_line(0);
    put_text("X"); line_bytes.push_back(ChAck); put_crlf(); send_line(0);

    // Random lines, with one long receiver hold-off and one drain pause.
    while (bytes_sent < 1150) begin
      if (bytes_sent > 600 && bytes_sent < 640 && hold_count == 0 && !hold_request)
        hold_request <= 1;
      if (bytes_sent > 900 && bytes_sent < 930) begin
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
      end
      if ($urandom_range(40) == 0) begin
        put_noise($urandom_range(20)); put_crlf(); send_line(1);
      end else begin
        random_line();
        send_line(0);
      end
    end
    in_valid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> sim.f
design/scl_pkg.sv
design/scl_ram.sv
design/scl_datapath.sv
design/scl_ctrl.sv
design/serial_command_line_recognizer.sv
sim/scl_checker.sv
sim/tb_top.sv
